FILE: hw/rtl/ccsc_pkg.sv
// Types and constants shared by the charge current search controller.
package ccsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_VOLT  = 2'd1;
    localparam logic [1:0] CMD_TEMP  = 2'd2;

    localparam logic [1:0] WANT_NONE = 2'd0;
    localparam logic [1:0] WANT_VOLT = 2'd1;
    localparam logic [1:0] WANT_TEMP = 2'd2;

    localparam logic [2:0] ST_SEARCHING = 3'd0;
    localparam logic [2:0] ST_CHARGING  = 3'd1;
    localparam logic [2:0] ST_STOPPED   = 3'd2;
    localparam logic [2:0] ST_ABORTED   = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_START_CURRENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_CURRENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT    = 3'd5;

    localparam logic [8:0]  RST_START_CURRENT = 9'd10;
    localparam logic [6:0]  RST_STEP_CURRENT  = 7'd5;
    localparam logic [8:0]  RST_MAX_CURRENT   = 9'd500;
    localparam logic [9:0]  RST_TOLERANCE     = 10'd50;
    localparam logic [8:0]  RST_DEVIATION     = 9'd10;
    localparam logic [12:0] RST_TEMP_LIMIT    = 13'd80;

    // Reciprocal of 25 scaled by 2**17, rounded up; exact for the quotients needed here.
    localparam logic [12:0] RECIP_25   = 13'd5243;
    localparam int          RECIP_SHIFT = 17;
    localparam logic [8:0]  DUTY_MAX   = 9'd255;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_SEARCH   = 7'b0000010,
        PH_WAIT_V   = 7'b0000100,
        PH_RESEARCH = 7'b0001000,
        PH_WAIT_T   = 7'b0010000,
        PH_STOPPED  = 7'b0100000,
        PH_ABORTED  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] duty;
        logic [8:0] current_ma;
        logic [1:0] want;
        logic [2:0] status;
    } t_result;

endpackage

FILE: hw/rtl/charge_current_search_controller.sv
// Charge current search controller: sweep sequencer, result register and skid stage.
//
//   Channel   Direction  Handshake             Payload
//   request   in         i_valid / o_stall     i_cmd, i_voltage_mv, i_temp_diff_centi
//   result    out        o_valid / i_stall     o_duty, o_current_ma, o_want, o_status
//   config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// Each request yields one registered result; one request per cycle is taken while o_stall is low.
// The state update and the duty scaling are done in the cycle of acceptance.
// A two-entry output register and skid stage absorb a stall; o_stall rises only
// when both are full. Reset is synchronous, active low, and restores the register
// defaults and the idle phase.
module charge_current_search_controller
    import ccsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_cmd,
    input  logic [12:0]           i_voltage_mv,
    input  logic signed [13:0]    i_temp_diff_centi,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_duty,
    output logic [8:0]            o_current_ma,
    output logic [1:0]            o_want,
    output logic [2:0]            o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [8:0]  r_start_current;
    logic [6:0]  r_step_current;
    logic [8:0]  r_max_current;
    logic [9:0]  r_tolerance;
    logic [8:0]  r_deviation;
    logic [12:0] r_temp_limit;

    t_phase      r_phase, n_phase;
    logic [9:0]  r_test, n_test;
    logic [8:0]  r_chosen, n_chosen;
    logic [12:0] r_ref, n_ref;
    logic [8:0]  r_applied, n_applied;

    t_result     r_out, r_skid, n_result;
    logic        r_out_valid, r_skid_valid;

    logic        accept;
    logic        start_over;
    logic [9:0]  test_next;
    logic        next_over;
    logic [14:0] match_diff;
    logic [13:0] match_abs;
    logic        is_match;
    logic [8:0]  dev_abs;
    logic        temp_over;
    logic [2:0]  status;
    logic [14:0] scaled51;
    logic [12:0] quarter;
    logic [25:0] recip_prod;
    logic [8:0]  duty_raw;

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_current <= RST_START_CURRENT;
            r_step_current  <= RST_STEP_CURRENT;
            r_max_current   <= RST_MAX_CURRENT;
            r_tolerance     <= RST_TOLERANCE;
            r_deviation     <= RST_DEVIATION;
            r_temp_limit    <= RST_TEMP_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_CURRENT: r_start_current <= i_cfg_data[8:0];
                REG_STEP_CURRENT:  r_step_current  <= i_cfg_data[6:0];
                REG_MAX_CURRENT:   r_max_current   <= i_cfg_data[8:0];
                REG_TOLERANCE:     r_tolerance     <= i_cfg_data[9:0];
                REG_DEVIATION:     r_deviation     <= i_cfg_data[8:0];
                REG_TEMP_LIMIT:    r_temp_limit    <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    assign start_over = r_start_current > r_max_current;
    assign test_next  = r_test + {3'b000, r_step_current};
    assign next_over  = test_next > {1'b0, r_max_current};
    assign match_diff = {1'b0, i_voltage_mv, 1'b0} - {2'b00, r_ref};
    assign match_abs  = match_diff[14] ? 14'(-match_diff) : match_diff[13:0];
    assign is_match   = match_abs < {3'b000, r_tolerance, 1'b0};
    assign dev_abs    = (r_test[8:0] > r_chosen) ? (r_test[8:0] - r_chosen)
                                                 : (r_chosen - r_test[8:0]);
    assign temp_over  = i_temp_diff_centi > $signed({1'b0, r_temp_limit});

    always_comb begin
        n_phase   = r_phase;
        n_test    = r_test;
        n_chosen  = r_chosen;
        n_ref     = r_ref;
        n_applied = r_applied;
        status    = ST_IGNORED;
        case (i_cmd)
            CMD_START: begin
                n_ref  = i_voltage_mv;
                n_test = {1'b0, r_start_current};
                if (start_over) begin
                    n_applied = '0;
                    n_phase   = PH_ABORTED;
                    status    = ST_ABORTED;
                end else begin
                    n_applied = r_start_current;
                    n_phase   = PH_SEARCH;
                    status    = ST_SEARCHING;
                end
            end
            CMD_VOLT: begin
                case (r_phase)
                    PH_SEARCH: begin
                        if (is_match) begin
                            n_chosen  = r_test[8:0];
                            n_applied = r_test[8:0];
                            n_phase   = PH_WAIT_V;
                            status    = ST_CHARGING;
                        end else begin
                            n_test = test_next;
                            if (next_over) begin
                                n_applied = '0;
                                n_phase   = PH_ABORTED;
                                status    = ST_ABORTED;
                            end else begin
                                n_applied = test_next[8:0];
                                status    = ST_SEARCHING;
                            end
                        end
                    end
                    PH_WAIT_V: begin
                        n_ref  = i_voltage_mv;
                        n_test = {1'b0, r_start_current};
                        if (start_over) begin
                            n_applied = r_chosen;
                            n_phase   = PH_WAIT_T;
                            status    = ST_CHARGING;
                        end else begin
                            n_applied = r_start_current;
                            n_phase   = PH_RESEARCH;
                            status    = ST_SEARCHING;
                        end
                    end
                    PH_RESEARCH: begin
                        if (is_match) begin
                            if (dev_abs > r_deviation) begin
                                n_chosen  = r_test[8:0];
                                n_applied = r_test[8:0];
                            end else begin
                                n_applied = r_chosen;
                            end
                            n_phase = PH_WAIT_T;
                            status  = ST_CHARGING;
                        end else begin
                            n_test = test_next;
                            if (next_over) begin
                                n_applied = r_chosen;
                                n_phase   = PH_WAIT_T;
                                status    = ST_CHARGING;
                            end else begin
                                n_applied = test_next[8:0];
                                status    = ST_SEARCHING;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_TEMP: begin
                if (r_phase == PH_WAIT_T) begin
                    if (temp_over) begin
                        n_applied = '0;
                        n_phase   = PH_STOPPED;
                        status    = ST_STOPPED;
                    end else begin
                        n_applied = r_chosen;
                        n_phase   = PH_WAIT_V;
                        status    = ST_CHARGING;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Duty is applied * 51 / 100: a quarter of applied * 51, then a division by 25.
    assign scaled51   = ({6'b0, n_applied} << 5) + ({6'b0, n_applied} << 4)
                      + ({6'b0, n_applied} << 1) + {6'b0, n_applied};
    assign quarter    = scaled51[14:2];
    assign recip_prod = {13'b0, quarter} * {13'b0, RECIP_25};
    assign duty_raw   = recip_prod[RECIP_SHIFT +: 9];

    always_comb begin
        n_result.duty       = (duty_raw > DUTY_MAX) ? DUTY_MAX[7:0] : duty_raw[7:0];
        n_result.current_ma = n_applied;
        n_result.status     = status;
        case (n_phase)
            PH_SEARCH, PH_WAIT_V, PH_RESEARCH: n_result.want = WANT_VOLT;
            PH_WAIT_T:                         n_result.want = WANT_TEMP;
            default:                           n_result.want = WANT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_test    <= '0;
            r_chosen  <= '0;
            r_ref     <= '0;
            r_applied <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_test    <= n_test;
            r_chosen  <= n_chosen;
            r_ref     <= n_ref;
            r_applied <= n_applied;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_duty       = r_out.duty;
    assign o_current_ma = r_out.current_ma;
    assign o_want       = r_out.want;
    assign o_status     = r_out.status;

endmodule

FILE: dv/charge_current_search_controller_tb.sv
// Self-checking testbench for the charge current search controller, with a scoreboard class.
`timescale 1ns / 100ps

import ccsc_pkg::*;

class charge_sweep_scoreboard;
    logic [8:0]  start_ma;
    logic [6:0]  step_ma;
    logic [8:0]  max_ma;
    logic [9:0]  tol_mv;
    logic [8:0]  dev_ma;
    logic [12:0] temp_limit;

    t_phase      phase;
    logic [9:0]  test_ma;
    logic [8:0]  chosen_ma;
    logic [12:0] ref_mv;
    logic [8:0]  applied_ma;

    t_result     due_results[$];
    int          errors;

    function new();
        start_ma   = RST_START_CURRENT;
        step_ma    = RST_STEP_CURRENT;
        max_ma     = RST_MAX_CURRENT;
        tol_mv     = RST_TOLERANCE;
        dev_ma     = RST_DEVIATION;
        temp_limit = RST_TEMP_LIMIT;
        phase      = PH_IDLE;
        test_ma    = '0;
        chosen_ma  = '0;
        ref_mv     = '0;
        applied_ma = '0;
        errors     = 0;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_START_CURRENT: start_ma   = data[8:0];
            REG_STEP_CURRENT:  step_ma    = data[6:0];
            REG_MAX_CURRENT:   max_ma     = data[8:0];
            REG_TOLERANCE:     tol_mv     = data[9:0];
            REG_DEVIATION:     dev_ma     = data[8:0];
            REG_TEMP_LIMIT:    temp_limit = data[12:0];
            default: ;
        endcase
    endfunction

    function logic [1:0] want_for(t_phase p);
        case (p)
            PH_SEARCH, PH_WAIT_V, PH_RESEARCH: return WANT_VOLT;
            PH_WAIT_T: return WANT_TEMP;
            default: return WANT_NONE;
        endcase
    endfunction

    // The sample matches when twice the voltage lies strictly within twice the
    // tolerance of the reference.
    function bit near_target(logic [12:0] v);
        int d;
        d = 2 * int'(v) - int'(ref_mv);
        if (d < 0) d = -d;
        return d < 2 * int'(tol_mv);
    endfunction

    function bit open_sweep(logic [12:0] v);
        ref_mv  = v;
        test_ma = {1'b0, start_ma};
        if (test_ma > max_ma) return 1'b0;
        applied_ma = test_ma[8:0];
        return 1'b1;
    endfunction

    function bit advance_sweep();
        test_ma = test_ma + step_ma;
        if (test_ma > max_ma) return 1'b0;
        applied_ma = test_ma[8:0];
        return 1'b1;
    endfunction

    function void note_request(logic [1:0] cmd, logic [12:0] v, logic signed [13:0] t);
        logic [2:0] st;
        logic [8:0] nc;
        int         diff;
        int         duty;
        t_result    r;
        st = ST_IGNORED;
        if (cmd == CMD_START) begin
            if (open_sweep(v)) begin
                phase = PH_SEARCH;
                st    = ST_SEARCHING;
            end else begin
                applied_ma = '0;
                phase      = PH_ABORTED;
                st         = ST_ABORTED;
            end
        end else if (cmd == CMD_VOLT && phase == PH_SEARCH) begin
            if (near_target(v)) begin
                chosen_ma  = test_ma[8:0];
                applied_ma = chosen_ma;
                phase      = PH_WAIT_V;
                st         = ST_CHARGING;
            end else if (advance_sweep()) begin
                st = ST_SEARCHING;
            end else begin
                applied_ma = '0;
                phase      = PH_ABORTED;
                st         = ST_ABORTED;
            end
        end else if (cmd == CMD_VOLT && phase == PH_WAIT_V) begin
            if (open_sweep(v)) begin
                phase = PH_RESEARCH;
                st    = ST_SEARCHING;
            end else begin
                applied_ma = chosen_ma;
                phase      = PH_WAIT_T;
                st         = ST_CHARGING;
            end
        end else if (cmd == CMD_VOLT && phase == PH_RESEARCH) begin
            if (near_target(v)) begin
                nc   = test_ma[8:0];
                diff = int'(nc) - int'(chosen_ma);
                if (diff < 0) diff = -diff;
                if (diff > int'(dev_ma)) chosen_ma = nc;
                applied_ma = chosen_ma;
                phase      = PH_WAIT_T;
                st         = ST_CHARGING;
            end else if (advance_sweep()) begin
                st = ST_SEARCHING;
            end else begin
                applied_ma = chosen_ma;
                phase      = PH_WAIT_T;
                st         = ST_CHARGING;
            end
        end else if (cmd == CMD_TEMP && phase == PH_WAIT_T) begin
            if (int'(t) > int'(temp_limit)) begin
                applied_ma = '0;
                phase      = PH_STOPPED;
                st         = ST_STOPPED;
            end else begin
                applied_ma = chosen_ma;
                phase      = PH_WAIT_V;
                st         = ST_CHARGING;
            end
        end
        duty = int'(applied_ma) * 255 / 500;
        if (duty > 255) duty = 255;
        r.duty       = duty[7:0];
        r.current_ma = applied_ma;
        r.want       = want_for(phase);
        r.status     = st;
        due_results.push_back(r);
    endfunction

    function void compare_field(string field, int predicted, int observed);
        if (predicted != observed) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, predicted, observed);
        end
    endfunction

    function void check_result(t_result got);
        t_result due;
        if (due_results.size() == 0) begin
            errors++;
            $display("%0t ns: result with none expected, actual duty %0d current %0d",
                     $time, got.duty, got.current_ma);
            $display("%0t ns: unexpected result, actual want %0d status %0d",
                     $time, got.want, got.status);
            return;
        end
        due = due_results.pop_front();
        compare_field("duty", due.duty, got.duty);
        compare_field("current_ma", due.current_ma, got.current_ma);
        compare_field("want", due.want, got.want);
        compare_field("status", due.status, got.status);
    endfunction
endclass

module charge_current_search_controller_tb;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         LIMIT      = 200000;

    typedef struct {
        logic [1:0] cmd;
        int         volt;
        int         temp;
    } t_request;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_cmd;
    logic [12:0]           i_voltage_mv;
    logic signed [13:0]    i_temp_diff_centi;
    logic                  o_valid;
    logic                  i_stall;
    logic [7:0]            o_duty;
    logic [8:0]            o_current_ma;
    logic [1:0]            o_want;
    logic [2:0]            o_status;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    charge_sweep_scoreboard board = new();
    bit idling_on    = 1'b1;
    bit hold_request = 1'b0;
    int cycles       = 0;

    charge_current_search_controller dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_voltage_mv      (i_voltage_mv),
        .i_temp_diff_centi (i_temp_diff_centi),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_duty            (o_duty),
        .o_current_ma      (o_current_ma),
        .o_want            (o_want),
        .o_status          (o_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                board.check_result(t_result'({o_duty, o_current_ma, o_want, o_status}));
            end
            if (i_valid && !o_stall) begin
                board.note_request(i_cmd, i_voltage_mv, i_temp_diff_centi);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold-off that lets the block fill up.
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 90;
                i_stall <= 1'b1;
            end else begin
                i_stall <= idling_on && ($urandom_range(0, 99) < 11);
            end
        end
    end

    task automatic send_request(input logic [1:0] cmd, input int volt, input int temp);
        while (idling_on && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_cmd             <= cmd;
        i_voltage_mv      <= 13'(volt);
        i_temp_diff_centi <= 14'(temp);
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        board.set_reg(idx, CFG_DATA_W'(value));
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input int first, input int step, input int top,
                                 input int tol, input int dev, input int limit);
        put_reg(REG_START_CURRENT, first);
        put_reg(REG_STEP_CURRENT, step);
        put_reg(REG_MAX_CURRENT, top);
        put_reg(REG_TOLERANCE, tol);
        put_reg(REG_DEVIATION, dev);
        put_reg(REG_TEMP_LIMIT, limit);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_setting();
        int top;
        int first;
        top   = $urandom_range(0, 500);
        first = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 500) : $urandom_range(0, top);
        apply_setting(first, $urandom_range(1, 100), top, $urandom_range(0, 1000),
                      $urandom_range(0, 500), $urandom_range(0, 8191));
    endtask

    // Mostly requests that suit the phase the block is in, with some noise.
    function automatic t_request pick_request();
        t_request r;
        int       half;
        int       tol;
        int       off;
        int       pick;
        r.cmd  = CMD_VOLT;
        r.volt = $urandom_range(0, 8191);
        r.temp = int'($urandom_range(0, 16383)) - 8192;
        if ($urandom_range(0, 99) < 6) begin
            r.cmd = 2'($urandom_range(0, 3));
            return r;
        end
        case (board.phase)
            PH_SEARCH, PH_RESEARCH: begin
                tol = board.tol_mv;
                if ($urandom_range(0, 99) < 2) begin
                    r.cmd = CMD_START;
                end else if (tol != 0 && $urandom_range(0, 99) < 30) begin
                    half = board.ref_mv / 2;
                    off  = int'($urandom_range(0, 2 * tol - 2)) - (tol - 1);
                    if ($urandom_range(0, 9) == 0) off = $urandom_range(0, 1) ? tol : -tol;
                    off = half + off;
                    if (off < 0) off = 0;
                    if (off > 8191) off = 8191;
                    r.volt = off;
                end
            end
            PH_WAIT_V: begin
                r.cmd = ($urandom_range(0, 99) < 3) ? CMD_START : CMD_VOLT;
            end
            PH_WAIT_T: begin
                r.cmd = CMD_TEMP;
                pick  = $urandom_range(0, 9);
                if (pick < 8) begin
                    r.temp = int'(board.temp_limit) - int'($urandom_range(0, 300));
                end else if (pick == 8) begin
                    r.temp = int'(board.temp_limit) + int'($urandom_range(0, 2));
                    if (r.temp > 8191) r.temp = 8191;
                end
            end
            default: begin
                r.cmd = CMD_START;
            end
        endcase
        return r;
    endfunction

    task automatic run_random(input int count);
        t_request r;
        repeat (count) begin
            r = pick_request();
            send_request(r.cmd, r.volt, r.temp);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_cmd             = CMD_START;
        i_voltage_mv      = '0;
        i_temp_diff_centi = '0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_START_CURRENT;
        i_cfg_data        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: ignored requests, a full charge cycle, re-search and a stop.
        send_request(CMD_UNUSED, 8191, 8191);
        send_request(CMD_VOLT, 100, 0);
        send_request(CMD_START, 8191, 0);
        send_request(CMD_VOLT, 0, 0);
        send_request(CMD_VOLT, 4070, 0);
        send_request(CMD_TEMP, 0, -8192);
        send_request(CMD_VOLT, 4000, 0);
        send_request(CMD_VOLT, 2000, 0);
        send_request(CMD_TEMP, 0, 80);
        send_request(CMD_VOLT, 1000, 0);
        send_request(CMD_VOLT, 0, 0);
        send_request(CMD_VOLT, 451, 0);
        send_request(CMD_TEMP, 0, -8192);
        send_request(CMD_VOLT, 6000, 0);
        send_request(CMD_VOLT, 3000, 0);
        send_request(CMD_TEMP, 0, 81);
        send_request(CMD_VOLT, 0, 0);
        settle();

        // Current above the duty full scale, and a sweep that does not move.
        apply_setting(505, 0, 511, 1, 0, 0);
        send_request(CMD_START, 100, 0);
        send_request(CMD_VOLT, 0, 0);
        send_request(CMD_VOLT, 50, 0);
        send_request(CMD_TEMP, 0, 1);
        settle();

        // Re-search that runs out keeps the old current; first search that runs out aborts.
        apply_setting(0, 100, 200, 1, 500, 8191);
        send_request(CMD_START, 1000, 0);
        send_request(CMD_VOLT, 0, 0);
        send_request(CMD_VOLT, 500, 0);
        send_request(CMD_VOLT, 4000, 0);
        send_request(CMD_VOLT, 0, 0);
        send_request(CMD_VOLT, 0, 0);
        send_request(CMD_VOLT, 0, 0);
        send_request(CMD_START, 2000, 0);
        send_request(CMD_VOLT, 0, 0);
        send_request(CMD_VOLT, 0, 0);
        send_request(CMD_VOLT, 0, 0);
        settle();

        apply_setting(10, 5, 500, 50, 10, 80);
        run_random(130);
        settle();

        apply_setting(0, 1, 0, 0, 0, 0);
        run_random(60);
        settle();

        apply_setting(500, 100, 500, 1000, 500, 8191);
        run_random(100);
        settle();

        random_setting();
        idling_on = 1'b0;
        run_random(220);
        settle();
        idling_on = 1'b1;

        random_setting();
        hold_request = 1'b1;
        run_random(150);
        settle();

        apply_setting(400, 7, 100, 200, 20, 300);
        run_random(60);
        settle();

        random_setting();
        run_random(180);
        settle();

        random_setting();
        run_random(180);
        settle();

        if (board.errors == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/ccsc_pkg.sv
hw/rtl/charge_current_search_controller.sv
dv/charge_current_search_controller_tb.sv
